// File: rtl/tfl_pkg.sv
package tfl_pkg;

  localparam int TFL_MAX_ENTRIES = 256;
  localparam int TFL_FRAC_BITS   = 16;

  localparam int SAMPLE_W    = 16;
  localparam int CH_W        = 16;
  localparam int IDX_W       = 8;
  localparam int ENTRIES_W   = 9;
  localparam int REQ_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COLOR_LANES = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_COLOR   = 2'd1,
    REQ_OPACITY = 2'd2
  } tfl_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW       = 2'd0,
    CFG_RANGE_HIGH      = 2'd1,
    CFG_COLOR_ENTRIES   = 2'd2,
    CFG_OPACITY_ENTRIES = 2'd3
  } tfl_cfg_e;

  typedef struct packed {
    logic             lookup;
    logic             wr_color;
    logic             wr_opacity;
    logic [IDX_W-1:0] idx;
  } tfl_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } tfl_wdata_t;

  typedef struct packed {
    logic             lookup;
    logic             wr;
    logic [IDX_W-1:0] idx;
  } tfl_tbl_ctl_t;

endpackage

// File: rtl/tfl_norm.sv
module tfl_norm #(
  parameter int FRAC_BITS = tfl_pkg::TFL_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  tfl_pkg::tfl_ctl_t             in_ctl,
  input  tfl_pkg::tfl_wdata_t           in_wdata,
  input  logic [tfl_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [tfl_pkg::SAMPLE_W-1:0]  range_low,
  input  logic [tfl_pkg::SAMPLE_W-1:0]  range_high,
  output tfl_pkg::tfl_ctl_t             out_ctl,
  output tfl_pkg::tfl_wdata_t           out_wdata,
  output logic [FRAC_BITS-1:0]          out_v
);
  import tfl_pkg::*;

  localparam int NS = FRAC_BITS + 1;

  logic [SAMPLE_W-1:0] span;
  logic [SAMPLE_W-1:0] diff;
  logic                zero;
  logic                sat;

  tfl_ctl_t             ctl_r   [NS];
  tfl_wdata_t           wdata_r [NS];
  logic [SAMPLE_W-1:0]  rem_r   [NS];
  logic [FRAC_BITS-1:0] quo_r   [NS];
  logic                 zero_r  [NS];
  logic                 sat_r   [NS];

  assign span = range_high - range_low;
  assign diff = in_sample - range_low;
  assign zero = (range_high <= range_low) || (in_sample <= range_low);
  assign sat  = diff >= span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wdata_r[0] <= in_wdata;
      rem_r[0]   <= diff;
      quo_r[0]   <= '0;
      zero_r[0]  <= zero;
      sat_r[0]   <= sat;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [SAMPLE_W:0]    dbl;
    logic                 ge;
    logic [SAMPLE_W-1:0]  rem_nxt;
    logic [FRAC_BITS-1:0] quo_nxt;

    assign dbl     = {rem_r[k], 1'b0};
    assign ge      = dbl >= {1'b0, span};
    assign rem_nxt = ge ? SAMPLE_W'(dbl - {1'b0, span}) : dbl[SAMPLE_W-1:0];
    assign quo_nxt = {quo_r[k][FRAC_BITS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wdata_r[k+1] <= wdata_r[k];
        rem_r[k+1]   <= rem_nxt;
        quo_r[k+1]   <= quo_nxt;
        zero_r[k+1]  <= zero_r[k];
        sat_r[k+1]   <= sat_r[k];
      end
    end
  end

  assign out_ctl   = ctl_r[FRAC_BITS];
  assign out_wdata = wdata_r[FRAC_BITS];
  assign out_v     = zero_r[FRAC_BITS] ? '0 :
                     sat_r[FRAC_BITS]  ? '1 : quo_r[FRAC_BITS];

endmodule

// File: rtl/tfl_table.sv
module tfl_table #(
  parameter int MAX_ENTRIES = tfl_pkg::TFL_MAX_ENTRIES,
  parameter int FRAC_BITS   = tfl_pkg::TFL_FRAC_BITS,
  parameter int LANES       = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  tfl_pkg::tfl_tbl_ctl_t             in_ctl,
  input  logic [LANES*tfl_pkg::CH_W-1:0]    in_wdata,
  input  logic [FRAC_BITS-1:0]              in_v,
  input  logic [tfl_pkg::ENTRIES_W-1:0]     entries,
  output logic                              out_vld,
  output logic [LANES*tfl_pkg::CH_W-1:0]    out_data
);
  import tfl_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int DW  = LANES * CH_W;
  localparam int PW  = FRAC_BITS + AW;
  localparam int NW  = (ENTRIES_W > AW + 1) ? ENTRIES_W : AW + 1;
  localparam int IXW = (IDX_W > AW + 1) ? IDX_W : AW + 1;
  localparam int MW  = CH_W + FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [DW-1:0] mem [MAX_ENTRIES];

  logic [NW-1:0]        n_ext;
  logic [NW-1:0]        n_use;
  logic [AW-1:0]        nm1;
  logic [PW-1:0]        p_nxt;
  logic [AW-1:0]        idx_lo;
  logic [AW-1:0]        idx_hi;
  logic [IXW-1:0]       idx_ext;
  logic                 idx_ok;

  tfl_tbl_ctl_t         ctl_a_r;
  logic [DW-1:0]        wdata_a_r;
  logic [PW-1:0]        p_r;
  logic                 vld_b_r;
  logic [DW-1:0]        rd_lo_r;
  logic [DW-1:0]        rd_hi_r;
  logic [FRAC_BITS-1:0] f_b_r;
  logic                 vld_c_r;
  logic                 vld_d_r;

  always_comb begin
    n_ext = NW'(entries);
    if (n_ext == '0) begin
      n_use = NW'(1);
    end else if (n_ext > NW'(MAX_ENTRIES)) begin
      n_use = NW'(MAX_ENTRIES);
    end else begin
      n_use = n_ext;
    end
    nm1 = AW'(n_use - NW'(1));
  end

  assign p_nxt = PW'(in_v) * PW'(nm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (en) begin
      ctl_a_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wdata_a_r <= in_wdata;
      p_r       <= p_nxt;
    end
  end

  assign idx_lo  = p_r[PW-1:FRAC_BITS];
  assign idx_hi  = (idx_lo == nm1) ? idx_lo : AW'(idx_lo + 1'b1);
  assign idx_ext = IXW'(ctl_a_r.idx);
  assign idx_ok  = idx_ext < IXW'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_a_r.wr && idx_ok) begin
        mem[idx_ext[AW-1:0]] <= wdata_a_r;
      end
      rd_lo_r <= mem[idx_lo];
      rd_hi_r <= mem[idx_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_b_r <= p_r[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= ctl_a_r.lookup;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MW-1:0]    prod_lo_r;
    logic [MW-1:0]    prod_hi_r;
    logic [MW:0]      sum;
    logic [CH_W-1:0]  res_r;

    always_ff @(posedge clk) begin
      if (en) begin
        prod_lo_r <= MW'(rd_lo_r[l*CH_W +: CH_W]) * MW'(ONE - (FRAC_BITS + 1)'(f_b_r));
        prod_hi_r <= MW'(rd_hi_r[l*CH_W +: CH_W]) * MW'(f_b_r);
      end
    end

    assign sum = (MW + 1)'(prod_lo_r) + (MW + 1)'(prod_hi_r);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r <= sum[FRAC_BITS +: CH_W];
      end
    end

    assign out_data[l*CH_W +: CH_W] = res_r;
  end

  assign out_vld = vld_d_r;

endmodule

// File: rtl/transfer_function_lookup.sv
// An input transfer passes the normalizing divider, the table index, read, product
// and result registers and the output register. Throughput: one item per cycle
// while the pipeline is not stalled; the normalizing divider is pipelined one quotient
// bit per stage and each table memory serves both interpolation reads every cycle.
// Reset is synchronous and active low: it clears the pipeline and restores the range
// and entry-count registers. The table memories are not cleared.
module transfer_function_lookup #(
  parameter int MAX_ENTRIES = tfl_pkg::TFL_MAX_ENTRIES,
  parameter int FRAC_BITS   = tfl_pkg::TFL_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tfl_pkg::REQ_W-1:0]       in_req_type,
  input  logic [tfl_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [tfl_pkg::IDX_W-1:0]       in_entry_index,
  input  logic [tfl_pkg::CH_W-1:0]        in_entry_red,
  input  logic [tfl_pkg::CH_W-1:0]        in_entry_green,
  input  logic [tfl_pkg::CH_W-1:0]        in_entry_blue,
  input  logic [tfl_pkg::CH_W-1:0]        in_entry_alpha,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tfl_pkg::CH_W-1:0]        out_red,
  output logic [tfl_pkg::CH_W-1:0]        out_green,
  output logic [tfl_pkg::CH_W-1:0]        out_blue,
  output logic [tfl_pkg::CH_W-1:0]        out_alpha_out,
  input  logic                            cfg_we,
  input  logic [tfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tfl_pkg::*;

  localparam int CDW = COLOR_LANES * CH_W;

  logic [SAMPLE_W-1:0]  range_low_r;
  logic [SAMPLE_W-1:0]  range_high_r;
  logic [ENTRIES_W-1:0] color_entries_r;
  logic [ENTRIES_W-1:0] opacity_entries_r;

  logic                 adv;
  logic                 accept;
  tfl_ctl_t             in_ctl;
  tfl_wdata_t           in_wdata;
  tfl_ctl_t             n_ctl;
  tfl_wdata_t           n_wdata;
  logic [FRAC_BITS-1:0] n_v;
  tfl_tbl_ctl_t         col_ctl;
  tfl_tbl_ctl_t         opa_ctl;
  logic                 col_vld;
  logic                 opa_vld;
  logic                 fin_vld;
  logic [CDW-1:0]       col_data;
  logic [CH_W-1:0]      opa_data;

  logic                 out_valid_r;
  logic [CH_W-1:0]      out_red_r;
  logic [CH_W-1:0]      out_green_r;
  logic [CH_W-1:0]      out_blue_r;
  logic [CH_W-1:0]      out_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r       <= '0;
      range_high_r      <= '1;
      color_entries_r   <= ENTRIES_W'(256);
      opacity_entries_r <= ENTRIES_W'(256);
    end else if (cfg_we) begin
      unique case (tfl_cfg_e'(cfg_index))
        CFG_RANGE_LOW:       range_low_r       <= cfg_data[SAMPLE_W-1:0];
        CFG_RANGE_HIGH:      range_high_r      <= cfg_data[SAMPLE_W-1:0];
        CFG_COLOR_ENTRIES:   color_entries_r   <= cfg_data[ENTRIES_W-1:0];
        CFG_OPACITY_ENTRIES: opacity_entries_r <= cfg_data[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is stuck behind a full output register.
  assign fin_vld  = col_vld & opa_vld;
  assign adv      = !out_valid_r || out_ready || !fin_vld;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_comb begin
    in_ctl.lookup     = accept && (in_req_type == REQ_LOOKUP);
    in_ctl.wr_color   = accept && (in_req_type == REQ_COLOR);
    in_ctl.wr_opacity = accept && (in_req_type == REQ_OPACITY);
    in_ctl.idx        = in_entry_index;
    in_wdata.red      = in_entry_red;
    in_wdata.green    = in_entry_green;
    in_wdata.blue     = in_entry_blue;
    in_wdata.alpha    = in_entry_alpha;
  end

  tfl_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_ctl     (in_ctl),
    .in_wdata   (in_wdata),
    .in_sample  (in_sample),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .out_ctl    (n_ctl),
    .out_wdata  (n_wdata),
    .out_v      (n_v)
  );

  always_comb begin
    col_ctl.lookup = n_ctl.lookup;
    col_ctl.wr     = n_ctl.wr_color;
    col_ctl.idx    = n_ctl.idx;
    opa_ctl.lookup = n_ctl.lookup;
    opa_ctl.wr     = n_ctl.wr_opacity;
    opa_ctl.idx    = n_ctl.idx;
  end

  tfl_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .FRAC_BITS   (FRAC_BITS),
    .LANES       (COLOR_LANES)
  ) u_color (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_ctl   (col_ctl),
    .in_wdata ({n_wdata.blue, n_wdata.green, n_wdata.red}),
    .in_v     (n_v),
    .entries  (color_entries_r),
    .out_vld  (col_vld),
    .out_data (col_data)
  );

  tfl_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .FRAC_BITS   (FRAC_BITS),
    .LANES       (1)
  ) u_opacity (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_ctl   (opa_ctl),
    .in_wdata (n_wdata.alpha),
    .in_v     (n_v),
    .entries  (opacity_entries_r),
    .out_vld  (opa_vld),
    .out_data (opa_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (fin_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_vld) begin
      out_red_r   <= col_data[0*CH_W +: CH_W];
      out_green_r <= col_data[1*CH_W +: CH_W];
      out_blue_r  <= col_data[2*CH_W +: CH_W];
      out_alpha_r <= opa_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha_out = out_alpha_r;

endmodule
